>>> rtl/lrbs_pkg.sv
package lrbs_pkg;

    // Input mode codes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_GOT    = 3'd1;
    localparam logic [2:0] MODE_DISC   = 3'd2;
    localparam logic [2:0] MODE_LOST   = 3'd3;
    localparam logic [2:0] MODE_FORCE  = 3'd4;
    localparam logic [2:0] MODE_BOOT   = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GIVE_UP    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_UPTIME = 1'd1;

    localparam logic [15:0] GIVE_UP_RST    = 16'd60000;
    localparam logic [15:0] MIN_UPTIME_RST = 16'd5000;

    // Backoff ladder
    localparam logic [2:0] LADDER_TOP = 3'd5;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Operation after classification
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_GOT,
        OP_DROP,
        OP_FORCE,
        OP_BOOT
    } op_t;

    // One queued item
    typedef struct packed {
        op_t         op;
        logic        keep_reason;
        logic [31:0] now_ms;
        logic [7:0]  reason_code;
    } entry_t;

    // Queue status towards the front and back ends
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    // One result item
    typedef struct packed {
        logic        reconnect_now;
        logic        throttled;
        logic        report_outage;
        logic        report_recovery;
        logic        refresh_naming;
        logic        link_up;
        logic [7:0]  last_reason;
        logic [15:0] backoff_ms;
        logic [31:0] connected_at;
        logic [31:0] disconnected_at;
    } result_t;

    function automatic logic [15:0] ladder_ms(input logic [2:0] step);
        logic [15:0] ms;
        unique case (step)
            3'd0:    ms = 16'd0;
            3'd1:    ms = 16'd1000;
            3'd2:    ms = 16'd2000;
            3'd3:    ms = 16'd5000;
            3'd4:    ms = 16'd15000;
            default: ms = 16'd60000;
        endcase
        return ms;
    endfunction

endpackage

>>> rtl/lrbs_if.sv
interface lrbs_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic [7:0]  reason_code;

    modport source (output valid, mode, now_ms, reason_code, input ready);
    modport sink   (input valid, mode, now_ms, reason_code, output ready);
endinterface

interface lrbs_out_if;
    logic        valid;
    logic        ready;
    logic        reconnect_now;
    logic        throttled;
    logic        report_outage;
    logic        report_recovery;
    logic        refresh_naming;
    logic        link_up;
    logic [7:0]  last_reason;
    logic [15:0] backoff_ms;
    logic [31:0] connected_at;
    logic [31:0] disconnected_at;

    modport source (output valid, reconnect_now, throttled, report_outage, report_recovery,
                    refresh_naming, link_up, last_reason, backoff_ms, connected_at,
                    disconnected_at, input ready);
    modport sink   (input valid, reconnect_now, throttled, report_outage, report_recovery,
                    refresh_naming, link_up, last_reason, backoff_ms, connected_at,
                    disconnected_at, output ready);
endinterface

interface lrbs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lrbs_pkg::CFG_ADDR_W-1:0] addr;
    logic [15:0]                     data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

>>> rtl/lrbs_front.sv
module lrbs_front (
    lrbs_in_if.sink           in_ch,
    input  logic              q_full,
    output logic              q_push,
    output lrbs_pkg::entry_t  q_entry
);

    lrbs_pkg::op_t op;

    // Classify the incoming mode
    always_comb
    begin
        unique case (in_ch.mode)
            lrbs_pkg::MODE_TICK:  op = lrbs_pkg::OP_TICK;
            lrbs_pkg::MODE_GOT:   op = lrbs_pkg::OP_GOT;
            lrbs_pkg::MODE_DISC:  op = lrbs_pkg::OP_DROP;
            lrbs_pkg::MODE_LOST:  op = lrbs_pkg::OP_DROP;
            lrbs_pkg::MODE_FORCE: op = lrbs_pkg::OP_FORCE;
            lrbs_pkg::MODE_BOOT:  op = lrbs_pkg::OP_BOOT;
            default:              op = lrbs_pkg::OP_NONE;
        endcase
    end

    // Accept whenever the queue has room
    assign in_ch.ready         = !q_full;
    assign q_push              = in_ch.valid && !q_full;
    assign q_entry.op          = op;
    assign q_entry.keep_reason = (in_ch.mode == lrbs_pkg::MODE_DISC);
    assign q_entry.now_ms      = in_ch.now_ms;
    assign q_entry.reason_code = in_ch.reason_code;

endmodule

>>> rtl/lrbs_queue.sv
module lrbs_queue #(
    parameter int unsigned DEPTH = lrbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lrbs_pkg::entry_t      push_entry,
    input  logic                  pop,
    output lrbs_pkg::entry_t      pop_entry,
    output lrbs_pkg::queue_stat_t stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lrbs_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/lrbs_back.sv
module lrbs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrbs_pkg::entry_t      q_entry,
    input  lrbs_pkg::queue_stat_t q_stat,
    output logic                  q_pop,
    lrbs_cfg_if.sink              cfg_ch,
    lrbs_out_if.source            out_ch
);

    // Configuration
    logic [15:0] give_up_reg, give_up_next;
    logic [15:0] min_up_reg, min_up_next;

    // Link state
    logic        up_reg, up_next;
    logic        seen_up_reg, seen_up_next;
    logic [31:0] up_since_reg, up_since_next;
    logic [31:0] down_since_reg, down_since_next;
    logic        pend_rebind_reg, pend_rebind_next;
    logic        pend_rec_reg, pend_rec_next;
    logic        pend_out_reg, pend_out_next;
    logic [7:0]  reason_reg, reason_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] next_try_reg, next_try_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    lrbs_pkg::result_t out_reg, out_next;

    logic [31:0] now;
    logic [31:0] since_up;
    logic [31:0] since_try;
    logic        blocks;
    logic [2:0]  fire_base;
    logic [2:0]  fire_step;
    logic [31:0] fire_at;
    logic        rc, thr, rep_out, rep_rec, refresh;

    assign cfg_ch.ready = 1'b1;

    // Take the head item when the output register is free or draining
    assign q_pop = !q_stat.empty && (!out_valid_reg || out_ch.ready);
    assign now   = q_entry.now_ms;

    // Shared time compares and ladder advance
    assign since_up  = now - up_since_reg;
    assign since_try = now - next_try_reg;
    assign blocks    = (step_reg != 3'd0) && since_try[31];
    assign fire_base = (q_entry.op == lrbs_pkg::OP_TICK && pend_rec_reg) ? 3'd0 : step_reg;
    assign fire_step = (fire_base >= lrbs_pkg::LADDER_TOP) ? lrbs_pkg::LADDER_TOP
                                                          : fire_base + 3'd1;
    assign fire_at   = now + {16'd0, lrbs_pkg::ladder_ms(fire_step)};

    // Execute one item
    always_comb
    begin
        up_next          = up_reg;
        seen_up_next     = seen_up_reg;
        up_since_next    = up_since_reg;
        down_since_next  = down_since_reg;
        pend_rebind_next = pend_rebind_reg;
        pend_rec_next    = pend_rec_reg;
        pend_out_next    = pend_out_reg;
        reason_next      = reason_reg;
        step_next        = step_reg;
        next_try_next    = next_try_reg;
        rc               = 1'b0;
        thr              = 1'b0;
        rep_out          = 1'b0;
        rep_rec          = 1'b0;
        refresh          = 1'b0;

        unique case (q_entry.op)
            lrbs_pkg::OP_TICK:
            begin
                rep_out          = pend_out_reg;
                pend_out_next    = 1'b0;
                rep_rec          = pend_rec_reg;
                pend_rec_next    = 1'b0;
                refresh          = pend_rebind_reg;
                pend_rebind_next = 1'b0;
                if (pend_rec_reg)
                begin
                    step_next     = 3'd0;
                    next_try_next = 32'd0;
                end
                if (!up_reg && seen_up_reg && (since_up >= {16'd0, give_up_reg})
                    && !(blocks && !pend_rec_reg))
                begin
                    rc            = 1'b1;
                    step_next     = fire_step;
                    next_try_next = fire_at;
                end
            end
            lrbs_pkg::OP_GOT:
            begin
                if (!up_reg)
                begin
                    up_next          = 1'b1;
                    seen_up_next     = 1'b1;
                    up_since_next    = now;
                    pend_rebind_next = 1'b1;
                    pend_rec_next    = 1'b1;
                end
            end
            lrbs_pkg::OP_DROP:
            begin
                if (q_entry.keep_reason)
                begin
                    reason_next = q_entry.reason_code;
                end
                if (up_reg)
                begin
                    up_next         = 1'b0;
                    down_since_next = now;
                    if (seen_up_reg && (since_up > {16'd0, min_up_reg}))
                    begin
                        pend_out_next = 1'b1;
                    end
                end
            end
            lrbs_pkg::OP_FORCE:
            begin
                if (blocks)
                begin
                    thr = 1'b1;
                end
                else
                begin
                    rc            = 1'b1;
                    step_next     = fire_step;
                    next_try_next = fire_at;
                end
            end
            lrbs_pkg::OP_BOOT:
            begin
                up_next          = 1'b1;
                seen_up_next     = 1'b1;
                up_since_next    = now;
                pend_rebind_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Build the result and hold it until transferred
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_next       = out_reg;
        if (q_pop)
        begin
            out_valid_next           = 1'b1;
            out_next.reconnect_now   = rc;
            out_next.throttled       = thr;
            out_next.report_outage   = rep_out;
            out_next.report_recovery = rep_rec;
            out_next.refresh_naming  = refresh;
            out_next.link_up         = up_next;
            out_next.last_reason     = reason_next;
            out_next.backoff_ms      = lrbs_pkg::ladder_ms(step_next);
            out_next.connected_at    = up_since_next;
            out_next.disconnected_at = down_since_next;
        end
    end

    // Configuration writes
    always_comb
    begin
        give_up_next = give_up_reg;
        min_up_next  = min_up_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.addr)
                lrbs_pkg::CFG_GIVE_UP:    give_up_next = cfg_ch.data;
                lrbs_pkg::CFG_MIN_UPTIME: min_up_next  = cfg_ch.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            give_up_reg     <= lrbs_pkg::GIVE_UP_RST;
            min_up_reg      <= lrbs_pkg::MIN_UPTIME_RST;
            up_reg          <= 1'b0;
            seen_up_reg     <= 1'b0;
            up_since_reg    <= 32'd0;
            down_since_reg  <= 32'd0;
            pend_rebind_reg <= 1'b0;
            pend_rec_reg    <= 1'b0;
            pend_out_reg    <= 1'b0;
            reason_reg      <= 8'd0;
            step_reg        <= 3'd0;
            next_try_reg    <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            give_up_reg   <= give_up_next;
            min_up_reg    <= min_up_next;
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                up_reg          <= up_next;
                seen_up_reg     <= seen_up_next;
                up_since_reg    <= up_since_next;
                down_since_reg  <= down_since_next;
                pend_rebind_reg <= pend_rebind_next;
                pend_rec_reg    <= pend_rec_next;
                pend_out_reg    <= pend_out_next;
                reason_reg      <= reason_next;
                step_reg        <= step_next;
                next_try_reg    <= next_try_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.reconnect_now   = out_reg.reconnect_now;
    assign out_ch.throttled       = out_reg.throttled;
    assign out_ch.report_outage   = out_reg.report_outage;
    assign out_ch.report_recovery = out_reg.report_recovery;
    assign out_ch.refresh_naming  = out_reg.refresh_naming;
    assign out_ch.link_up         = out_reg.link_up;
    assign out_ch.last_reason     = out_reg.last_reason;
    assign out_ch.backoff_ms      = out_reg.backoff_ms;
    assign out_ch.connected_at    = out_reg.connected_at;
    assign out_ch.disconnected_at = out_reg.disconnected_at;

endmodule

>>> rtl/link_reconnect_backoff_supervisor_core.sv
// Channel   Role  Transfer when        Carries
// in_ch     sink  valid && ready       mode, now_ms, reason_code
// out_ch    src   valid && ready       pulses, link_up, last_reason, backoff, timestamps
// cfg_ch    sink  valid && ready       addr (register index), data
//
// One item per cycle while out_ch.ready stays high; an item is registered in the queue,
// then its result in the output register, which holds it until out_ch.ready.
// The queue of QUEUE_DEPTH entries lets the front keep accepting while a result
// waits; in_ch.ready falls only when the queue is full.
// Reset clears all link state and loads the register defaults; no clearing pass.
module link_reconnect_backoff_supervisor_core #(
    parameter int unsigned QUEUE_DEPTH = lrbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lrbs_in_if.sink     in_ch,
    lrbs_out_if.source  out_ch,
    lrbs_cfg_if.sink    cfg_ch
);

    logic                  q_push;
    logic                  q_pop;
    lrbs_pkg::entry_t      push_entry;
    lrbs_pkg::entry_t      pop_entry;
    lrbs_pkg::queue_stat_t q_stat;

    lrbs_front u_front (
        .in_ch   (in_ch),
        .q_full  (q_stat.full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    lrbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .stat       (q_stat)
    );

    lrbs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_entry (pop_entry),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .cfg_ch  (cfg_ch),
        .out_ch  (out_ch)
    );

`ifndef SYNTH
    // A result never both fires and refuses a reconnect
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.reconnect_now && out_ch.throttled))
        else $error("reconnect and throttle raised together");

    // Backoff never exceeds the ladder's top
    a_backoff_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.backoff_ms <= 16'd60000))
        else $error("backoff beyond ladder top");

    // Queue cannot be empty and full at once
    a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue status inconsistent");

    // A pop only happens while the queue is non-empty
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule
